// ===== rtl/fpmt_pkg.sv =====
// shared types, constants and codes of the four-pad multitap
`default_nettype none
package fpmt_pkg;

  // field widths
  localparam int unsigned LINE_W   = 7;
  localparam int unsigned CNT_W    = 8;
  localparam int unsigned CODE_W   = 4;
  localparam int unsigned BTN_W    = 12;
  localparam int unsigned NUM_PADS = 4;
  localparam int unsigned NUM_PORTS = 2;
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 4;
  localparam int unsigned NUM_CFG_REGS = NUM_PORTS * NUM_PADS;

  // device code of a pad that sends only two status nibbles
  localparam logic [CODE_W-1:0] THREE_BUTTON_CODE = 4'h0;

  // line codes
  localparam logic [LINE_W-1:0] LINE_RESET    = 7'h60;
  localparam logic [LINE_W-1:0] LINE_TH_TR    = 7'h60;
  localparam logic [LINE_W-1:0] LINE_TH       = 7'h40;
  localparam logic [LINE_W-1:0] LINE_TR       = 7'h20;
  localparam logic [LINE_W-1:0] IDLE_CODE     = 7'h73;
  localparam logic [LINE_W-1:0] START_CODE    = 7'h3F;
  localparam logic [CODE_W-1:0] PAST_END_NIB  = 4'hF;
  localparam logic [CNT_W-1:0]  CNT_MAX       = 8'hFF;

  // sequence positions
  localparam logic [CNT_W-1:0] SEQ_IDLE   = 8'd0;
  localparam logic [CNT_W-1:0] SEQ_START  = 8'd1;
  localparam logic [CNT_W-1:0] SEQ_TYPES  = 8'd4;
  localparam logic [CNT_W-1:0] SEQ_STATUS = 8'd8;

  // access kinds
  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } fpmt_op_t;

  typedef logic [NUM_PADS-1:0][CODE_W-1:0] fpmt_pad_types_t;
  typedef logic [NUM_PADS-1:0][BTN_W-1:0]  fpmt_buttons_t;

  // one accepted input item
  typedef struct packed {
    fpmt_op_t          op;
    logic              port;
    logic [LINE_W-1:0] data;
    logic [LINE_W-1:0] mask;
    fpmt_buttons_t     buttons;
  } fpmt_item_t;

endpackage
`default_nettype wire

// ===== rtl/fpmt_if.sv =====
// handshake channels of the multitap: input items, results, register writes
`default_nettype none
interface fpmt_in_if import fpmt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic              port;
  logic [LINE_W-1:0] data;
  logic [LINE_W-1:0] mask;
  logic [BTN_W-1:0]  pad_a_buttons;
  logic [BTN_W-1:0]  pad_b_buttons;
  logic [BTN_W-1:0]  pad_c_buttons;
  logic [BTN_W-1:0]  pad_d_buttons;

  modport source (output valid, op, port, data, mask, pad_a_buttons, pad_b_buttons,
                  pad_c_buttons, pad_d_buttons, input ready);
  modport sink (input valid, op, port, data, mask, pad_a_buttons, pad_b_buttons,
                pad_c_buttons, pad_d_buttons, output ready);
endinterface

interface fpmt_out_if import fpmt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [LINE_W-1:0] read_value;

  modport source (output valid, read_value, input ready);
  modport sink (input valid, read_value, output ready);
endinterface

interface fpmt_cfg_if import fpmt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, addr, wdata, input ready);
  modport sink (input valid, addr, wdata, output ready);
endinterface
`default_nettype wire

// ===== rtl/fpmt_read_mux.sv =====
// read data selection: fixed codes, pad types and inverted button nibbles
`default_nettype none
module fpmt_read_mux import fpmt_pkg::*; (
  input  wire logic [CNT_W-1:0]  cnt,
  input  wire logic              tl,
  input  wire fpmt_pad_types_t   types,
  input  wire fpmt_buttons_t     buttons,
  output logic [LINE_W-1:0]      read_value
);

  logic [NUM_PADS-1:0][CODE_W-1:0] pad_len;
  logic [NUM_PADS-1:0][CODE_W-1:0] pad_end;
  logic [CNT_W-1:0]                status_idx;
  logic [CNT_W-1:0]                offset;
  logic [CODE_W-1:0]               nib;
  logic                            found;

  // nibble count of each pad and running end position
  always_comb begin
    for (int n = 0; n < NUM_PADS; n++) begin
      pad_len[n] = (types[n] == THREE_BUTTON_CODE) ? 4'd2 : 4'd3;
    end
    pad_end[0] = pad_len[0];
    for (int n = 1; n < NUM_PADS; n++) begin
      pad_end[n] = pad_end[n-1] + pad_len[n];
    end
  end

  // pick the pad and nibble for a status read
  always_comb begin
    status_idx = cnt - SEQ_STATUS;
    nib        = PAST_END_NIB;
    found      = 1'b0;
    offset     = '0;
    for (int n = 0; n < NUM_PADS; n++) begin
      if (!found && status_idx < {4'd0, pad_end[n]}) begin
        found  = 1'b1;
        offset = status_idx - {4'd0, pad_end[n]} + {4'd0, pad_len[n]};
        case (offset[1:0])
          2'd0:    nib = ~buttons[n][3:0];
          2'd1:    nib = ~buttons[n][7:4];
          default: nib = ~buttons[n][11:8];
        endcase
      end
    end
  end

  // sequence position decode
  always_comb begin
    if (cnt == SEQ_IDLE) begin
      read_value = IDLE_CODE;
    end else if (cnt == SEQ_START) begin
      read_value = START_CODE;
    end else if (cnt < SEQ_TYPES) begin
      read_value = {2'b00, tl, 4'h0};
    end else if (cnt < SEQ_STATUS) begin
      read_value = {2'b00, tl, types[cnt[1:0]]};
    end else begin
      read_value = {2'b00, tl, nib};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/four_pad_multitap_handshake_core.sv =====
// top level of the four-pad multitap: item register, port state, result register
//
//   channel   dir  fields                                         item
//   in_ch     in   op port data mask pad_a..pad_d_buttons          one bus access
//   out_ch    out  read_value                                     one per read access
//   cfg_ch    in   addr wdata                                     pad type write
//
// an item is registered on accept and handled as it advances: a write that changes
// TH or TR updates the port's line state and sequence counter, a read loads the
// result register. one item per cycle sustained unless a held result stalls a read;
// a read's result goes from the item register into the result register.
// a held result stalls a read item and the input behind it; a write item advances.
// synchronous active-low reset: line state 0x60, counters and pad types zero.
`default_nettype none
module four_pad_multitap_handshake_core import fpmt_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  fpmt_in_if.sink        in_ch,
  fpmt_out_if.source     out_ch,
  fpmt_cfg_if.sink       cfg_ch
);

  fpmt_pad_types_t            pad_type_r [NUM_PORTS];
  logic [LINE_W-1:0]          line_state_r [NUM_PORTS];
  logic [CNT_W-1:0]           seq_cnt_r [NUM_PORTS];

  logic                       s1_valid_r;
  fpmt_item_t                 s1_item_r;
  logic                       out_valid_r;
  logic [LINE_W-1:0]          out_value_r;

  logic                       s1_adv;
  logic                       in_fire;
  logic                       is_write;
  logic [LINE_W-1:0]          cur_line;
  logic [LINE_W-1:0]          line_nxt;
  logic [CNT_W-1:0]           cnt_nxt;
  logic                       line_change;
  logic [LINE_W-1:0]          rd_value;

  // handshakes
  assign is_write     = (s1_item_r.op == OP_WRITE);
  assign s1_adv       = s1_valid_r && (is_write || !out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_value = out_value_r;

  // item register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.op      <= fpmt_op_t'(in_ch.op);
      s1_item_r.port    <= in_ch.port;
      s1_item_r.data    <= in_ch.data;
      s1_item_r.mask    <= in_ch.mask;
      s1_item_r.buttons <= {in_ch.pad_d_buttons, in_ch.pad_c_buttons,
                            in_ch.pad_b_buttons, in_ch.pad_a_buttons};
    end
  end

  // masked line merge and counter step
  always_comb begin
    cur_line    = line_state_r[s1_item_r.port];
    line_nxt    = (cur_line & ~s1_item_r.mask) | (s1_item_r.data & s1_item_r.mask);
    line_change = |((cur_line ^ line_nxt) & LINE_TH_TR);
    if ((line_nxt & LINE_TH) != '0) begin
      cnt_nxt = '0;
    end else if (seq_cnt_r[s1_item_r.port] != CNT_MAX) begin
      cnt_nxt = seq_cnt_r[s1_item_r.port] + 8'd1;
    end else begin
      cnt_nxt = CNT_MAX;
    end
  end

  // port state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NUM_PORTS; p++) begin
        line_state_r[p] <= LINE_RESET;
        seq_cnt_r[p]    <= '0;
      end
    end else if (s1_adv && is_write && line_change) begin
      line_state_r[s1_item_r.port] <= line_nxt;
      seq_cnt_r[s1_item_r.port]    <= cnt_nxt;
    end
  end

  // pad type registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NUM_PORTS; p++) begin
        pad_type_r[p] <= '0;
      end
    end else if (cfg_ch.valid && cfg_ch.addr < CFG_ADDR_W'(NUM_CFG_REGS)) begin
      pad_type_r[cfg_ch.addr[2]][cfg_ch.addr[1:0]] <= cfg_ch.wdata;
    end
  end

  // read data
  fpmt_read_mux u_read_mux (
    .cnt        (seq_cnt_r[s1_item_r.port]),
    .tl         (|(line_state_r[s1_item_r.port] & LINE_TR)),
    .types      (pad_type_r[s1_item_r.port]),
    .buttons    (s1_item_r.buttons),
    .read_value (rd_value)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && !is_write) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && !is_write) begin
      out_value_r <= rd_value;
    end
  end

  // checks
  a_read_gives_item: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && !is_write |=> out_valid_r)
    else $error("read item did not reach the result register");

  a_write_no_item: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && is_write && out_valid_r && out_ch.ready |=> !out_valid_r)
    else $error("write item produced a result");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && seq_cnt_r[0] != $past(seq_cnt_r[0]) |->
      seq_cnt_r[0] == '0 || seq_cnt_r[0] == $past(seq_cnt_r[0]) + 8'd1)
    else $error("sequence counter jumped");

endmodule
`default_nettype wire
